// ===== rtl/core/rgb_to_hsl_pixel_converter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// rgb to hsl converter assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_PIXEL_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSL_PIXEL_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTH

// check that is switched off while reset is high
`define R2H_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("r2h check failed");

// check that also holds during reset
`define R2H_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("r2h check failed");

`else

`define R2H_ASSERT(label, clk, rst, prop)
`define R2H_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/r2h_pkg.sv =====
// ----------------------------------------------------------------------------
// r2h package
// widths, hue constants and stage payload types of the rgb to hsl converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package r2h_pkg;

   localparam int CHAN_W = 8;
   localparam int SUM_W = CHAN_W + 1;
   localparam int HUE_W = 15;
   localparam int SAT_W = 16;

   // long division: 24 dividend bits, 8 bit divisor, one bit per stage
   localparam int DIV_DIVIDEND_W = 24;
   localparam int DIV_DIVISOR_W = CHAN_W;

   // hue fraction: quotient of 15 * rem * 256 / d, below 3840
   localparam int HUE_FRAC_W = 12;
   localparam int HUE_NUM_W = 12;
   localparam int HUE_PAD_W = 8;

   // 60 degrees in 1/64 degree units
   localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
   localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 15'd3840;
   localparam logic [HUE_W-1:0] HUE_BASE_BLUE = 15'd11520;
   localparam logic [HUE_W-1:0] HUE_BASE_RED_WRAP = 15'd19200;
   localparam logic [SUM_W-1:0] SUM_FULL = 9'd510;
   localparam logic [SUM_W-1:0] SUM_HALF = 9'd255;

   typedef struct packed {
      logic [SUM_W-1:0]  x;
      logic [CHAN_W-1:0] diff;
      logic [CHAN_W-1:0] den;
      logic [SUM_W-1:0]  sum;
      logic [HUE_W-1:0]  base;
   } s1_type;

   typedef struct packed {
      logic              grey;
      logic [HUE_W-1:0]  base;
      logic [SUM_W-1:0]  sum;
   } side_type;

   typedef struct packed {
      logic [DIV_DIVIDEND_W-1:0] hue_dividend;
      logic [DIV_DIVISOR_W-1:0]  hue_divisor;
      logic [DIV_DIVIDEND_W-1:0] sat_dividend;
      logic [DIV_DIVISOR_W-1:0]  sat_divisor;
      side_type                  side;
   } s2_type;

endpackage

// ===== rtl/core/rgb_to_hsl_pixel_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb to hsl pixel converter unit: converts one 8 bit rgb pixel a clock
// (unless stalled) into hue, saturation and lightness sum
// ----------------------------------------------------------------------------
// usage
//  - request channel req_valid / req_ready carries red, green and blue
//  - response channel rsp_valid / rsp_ready carries hue (1/64 degree, floor),
//    saturation (q0.16, full scale clamped to 65535) and max plus min
//  - unless stalled, a request may enter every clock: one pixel per cycle
//  - from request acceptance to rsp_valid a pixel passes the max/min stage,
//    the divider set-up stage, the two 24 stage long dividers (one quotient
//    bit per stage) and the output register
//  - the whole pipeline moves as one: when a response waits and rsp_ready
//    is low every stage holds, req_ready drops, nothing is lost or repeated
//  - bubbles travel as cleared valid bits and are dropped at the output
//  - reset (synchronous, active high) clears every valid bit; the data path
//    has no reset and there is no state beyond the items in flight
//  - a grey pixel gives hue and saturation zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rgb_to_hsl_pixel_converter_unit_assert.svh"

module rgb_to_hsl_pixel_converter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [r2h_pkg::CHAN_W-1:0]    req_red,
   input  logic [r2h_pkg::CHAN_W-1:0]    req_green,
   input  logic [r2h_pkg::CHAN_W-1:0]    req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [r2h_pkg::HUE_W-1:0]     rsp_hue,
   output logic [r2h_pkg::SAT_W-1:0]     rsp_saturation,
   output logic [r2h_pkg::SUM_W-1:0]     rsp_lightness_sum
);

   localparam int STEPS = r2h_pkg::DIV_DIVIDEND_W;

   // pipeline-wide enable: move when the output slot is free or being taken
   logic advance;

   logic                  v1_ff;
   logic                  v2_ff;
   logic                  vdiv_ff [STEPS];
   logic                  out_valid_ff;

   r2h_pkg::s1_type       s1_in;
   r2h_pkg::s1_type       s1_ff;
   r2h_pkg::s2_type       s2_in;
   r2h_pkg::s2_type       s2_ff;
   r2h_pkg::side_type     side_ff [STEPS];

   logic [r2h_pkg::HUE_W-1:0] hue_in;
   logic [r2h_pkg::HUE_W-1:0] hue_ff;
   logic [r2h_pkg::SAT_W-1:0] sat_in;
   logic [r2h_pkg::SAT_W-1:0] sat_ff;
   logic [r2h_pkg::SUM_W-1:0] sum_ff;

   logic [r2h_pkg::DIV_DIVIDEND_W-1:0] hue_quot;
   logic [r2h_pkg::DIV_DIVIDEND_W-1:0] sat_quot;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ------------------------------------------------------------------
   // stage 1: max/min, chroma, lightness sum, saturation denominator and
   // hue numerator x in 0..2d with the sector base
   // ------------------------------------------------------------------
   logic                        red_max;
   logic                        green_max;
   logic [r2h_pkg::CHAN_W-1:0]  hi;
   logic [r2h_pkg::CHAN_W-1:0]  lo;
   logic [r2h_pkg::CHAN_W-1:0]  add_a;
   logic [r2h_pkg::CHAN_W-1:0]  sub_c;
   logic [r2h_pkg::CHAN_W-1:0]  add_d;
   logic [r2h_pkg::SUM_W:0]     x_wide;
   logic [r2h_pkg::SUM_W-1:0]   sum_c;
   logic [r2h_pkg::SUM_W-1:0]   den_hi;

   always_comb begin
      // ties go to red first, then green
      red_max   = (req_red >= req_green) && (req_red >= req_blue);
      green_max = !red_max && (req_green >= req_blue);

      priority if (red_max) begin
         hi = req_red;
      end else if (green_max) begin
         hi = req_green;
      end else begin
         hi = req_blue;
      end

      lo = req_red;
      if (req_green < lo) begin
         lo = req_green;
      end
      if (req_blue < lo) begin
         lo = req_blue;
      end

      sum_c  = {1'b0, hi} + {1'b0, lo};
      den_hi = r2h_pkg::SUM_FULL - sum_c;

      s1_in.diff = hi - lo;
      s1_in.sum  = sum_c;
      s1_in.den  = (sum_c <= r2h_pkg::SUM_HALF) ? sum_c[r2h_pkg::CHAN_W-1:0]
                                                 : den_hi[r2h_pkg::CHAN_W-1:0];

      // hue = base + floor(3840 * x / d), x = add_d + add_a - sub_c
      add_d = s1_in.diff;
      priority if (red_max) begin
         add_a = req_green;
         sub_c = req_blue;
         if (req_green >= req_blue) begin
            add_d      = '0;
            s1_in.base = '0;
         end else begin
            s1_in.base = r2h_pkg::HUE_BASE_RED_WRAP;
         end
      end else if (green_max) begin
         add_a      = req_blue;
         sub_c      = req_red;
         s1_in.base = r2h_pkg::HUE_BASE_GREEN;
      end else begin
         add_a      = req_red;
         sub_c      = req_green;
         s1_in.base = r2h_pkg::HUE_BASE_BLUE;
      end

      x_wide  = {2'b00, add_d} + {2'b00, add_a} - {2'b00, sub_c};
      s1_in.x = x_wide[r2h_pkg::SUM_W-1:0];
   end

   // ------------------------------------------------------------------
   // stage 2: integer part of x/d folded into the base, the remainder
   // times 15 becomes the hue dividend; grey pixels get divisor one
   // ------------------------------------------------------------------
   logic [r2h_pkg::SUM_W-1:0]     twice_d;
   logic                          ge2;
   logic                          ge1;
   logic [r2h_pkg::SUM_W-1:0]     rem0;
   logic [r2h_pkg::HUE_NUM_W-1:0] hue_num;
   logic [r2h_pkg::HUE_W-1:0]     base_step;
   logic                          grey;

   always_comb begin
      twice_d = {s1_ff.diff, 1'b0};
      ge2     = s1_ff.x >= twice_d;
      ge1     = s1_ff.x >= {1'b0, s1_ff.diff};
      grey    = s1_ff.diff == '0;

      priority if (ge2) begin
         rem0      = s1_ff.x - twice_d;
         base_step = {r2h_pkg::HUE_SECTOR[r2h_pkg::HUE_W-2:0], 1'b0};
      end else if (ge1) begin
         rem0      = s1_ff.x - {1'b0, s1_ff.diff};
         base_step = r2h_pkg::HUE_SECTOR;
      end else begin
         rem0      = s1_ff.x;
         base_step = '0;
      end

      // 15 * rem, rem below d
      hue_num = {rem0[r2h_pkg::CHAN_W-1:0], 4'b0000}
              - r2h_pkg::HUE_NUM_W'(rem0[r2h_pkg::CHAN_W-1:0]);

      s2_in.hue_dividend = r2h_pkg::DIV_DIVIDEND_W'({hue_num,
                                                   {r2h_pkg::HUE_PAD_W{1'b0}}});
      s2_in.hue_divisor  = grey ? r2h_pkg::DIV_DIVISOR_W'(1) : s1_ff.diff;
      s2_in.sat_dividend = {s1_ff.diff, {r2h_pkg::SAT_W{1'b0}}};
      s2_in.sat_divisor  = grey ? r2h_pkg::DIV_DIVISOR_W'(1) : s1_ff.den;
      s2_in.side.grey    = grey;
      s2_in.side.base    = s1_ff.base + base_step;
      s2_in.side.sum     = s1_ff.sum;
   end

   // ------------------------------------------------------------------
   // dividers: hue fraction and saturation, side data delayed alongside
   // ------------------------------------------------------------------
   r2h_divider #(
      .DIVIDEND_W (r2h_pkg::DIV_DIVIDEND_W),
      .DIVISOR_W  (r2h_pkg::DIV_DIVISOR_W)
   ) u_hue_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (s2_ff.hue_dividend),
      .divisor  (s2_ff.hue_divisor),
      .quotient (hue_quot)
   );

   r2h_divider #(
      .DIVIDEND_W (r2h_pkg::DIV_DIVIDEND_W),
      .DIVISOR_W  (r2h_pkg::DIV_DIVISOR_W)
   ) u_sat_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (s2_ff.sat_dividend),
      .divisor  (s2_ff.sat_divisor),
      .quotient (sat_quot)
   );

   // ------------------------------------------------------------------
   // output: hue, sat 0 for grey; else add hue fraction, clamp full saturation
   // ------------------------------------------------------------------
   always_comb begin
      if (side_ff[STEPS-1].grey) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = side_ff[STEPS-1].base
                + r2h_pkg::HUE_W'(hue_quot[r2h_pkg::HUE_FRAC_W-1:0]);
         sat_in = sat_quot[r2h_pkg::SAT_W] ? '1 : sat_quot[r2h_pkg::SAT_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < STEPS; i++) begin
            vdiv_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         vdiv_ff[0]   <= v2_ff;
         for (int i = 1; i < STEPS; i++) begin
            vdiv_ff[i] <= vdiv_ff[i-1];
         end
         out_valid_ff <= vdiv_ff[STEPS-1];
      end
   end

   // data path
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         side_ff[0] <= s2_ff.side;
         for (int i = 1; i < STEPS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         sum_ff <= side_ff[STEPS-1].sum;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_hue           = hue_ff;
   assign rsp_saturation    = sat_ff;
   assign rsp_lightness_sum = sum_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   `R2H_ASSERT(a_hue_range, clock, reset,
      rsp_valid |-> (rsp_hue <= 15'd23039))
   `R2H_ASSERT(a_chroma_sat, clock, reset,
      (rsp_valid && (rsp_hue != '0)) |-> (rsp_saturation != '0))
   `R2H_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid)

endmodule

// ===== rtl/core/r2h_divider.sv =====
// ----------------------------------------------------------------------------
// r2h divider
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module r2h_divider #(
   parameter int DIVIDEND_W = r2h_pkg::DIV_DIVIDEND_W,
   parameter int DIVISOR_W = r2h_pkg::DIV_DIVISOR_W
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEPS = DIVIDEND_W;

   // remainder and divisor are not needed after the last stage
   logic [DIVISOR_W-1:0]  rem_ff  [STEPS-1];
   logic [DIVISOR_W-1:0]  dsr_ff  [STEPS-1];
   logic [DIVIDEND_W-1:0] work_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [DIVISOR_W-1:0]  rem_src;
      logic [DIVISOR_W-1:0]  dsr_src;
      logic [DIVIDEND_W-1:0] work_src;
      logic [DIVISOR_W:0]    trial;
      logic                  fits;
      logic [DIVIDEND_W-1:0] work_in;

      if (i == 0) begin : g_first
         assign rem_src  = '0;
         assign dsr_src  = divisor;
         assign work_src = dividend;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign dsr_src  = dsr_ff[i-1];
         assign work_src = work_ff[i-1];
      end

      // shift next dividend bit into the partial remainder
      assign trial   = {rem_src, work_src[DIVIDEND_W-1]};
      assign fits    = trial >= {1'b0, dsr_src};
      assign work_in = {work_src[DIVIDEND_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (advance) begin
            work_ff[i] <= work_in;
         end
      end

      if (i < STEPS - 1) begin : g_carry
         logic [DIVISOR_W-1:0] rem_in;
         logic [DIVISOR_W:0]   diff;

         assign diff   = trial - {1'b0, dsr_src};
         assign rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[i] <= rem_in;
               dsr_ff[i] <= dsr_src;
            end
         end
      end
   end

   assign quotient = work_ff[STEPS-1];

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// rgb to hsl pixel converter testbench
// drives corner pixels, then random bursts, through the request channel, stalls the
// response channel on its own pattern and checks every response against an
// independent integer prediction of hue, saturation and lightness sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   // hue scale: one 60 degree sector and the full circle in 1/64 degree units
   localparam int HUE_UNITS_PER_SECTOR = 3840;
   localparam int HUE_UNITS_FULL = 23040;
   localparam int SAT_FULL_SCALE = 65536;

   localparam int RANDOM_PIXELS = 1630;
   localparam int BACKUP_AT = 400;       // accepted requests before the long hold-off
   localparam int BACKUP_CYCLES = 300;   // response hold-off, far beyond pipeline depth
   localparam int PAUSE_AT = 1100;       // random index where the sender drains the block
   localparam int SETTLE_CYCLES = 40;    // settle time after the last drain, beyond the pipeline latency
   localparam int STALL_LIMIT = 5000;    // cycles without any handshake before giving up

   typedef struct packed {
      logic [r2h_pkg::HUE_W-1:0] hue;
      logic [r2h_pkg::SAT_W-1:0] saturation;
      logic [r2h_pkg::SUM_W-1:0] lightness_sum;
   } hsl_result_type;

   // ------------------------------------------------------------------------
   // scoreboard: predicts each accepted pixel and matches responses in order
   // ------------------------------------------------------------------------
   class pixel_scoreboard;
      hsl_result_type awaited[$];
      int unsigned failures;

      function new();
         failures = 0;
      endfunction

      // exact integer hsl of one pixel
      function hsl_result_type convert_pixel(logic [r2h_pkg::CHAN_W-1:0] r,
                                             logic [r2h_pkg::CHAN_W-1:0] g,
                                             logic [r2h_pkg::CHAN_W-1:0] b);
         int red, green, blue, top, bottom, spread, sum, den, numer, hue;
         longint sat;
         hsl_result_type res;
         red = int'(r);
         green = int'(g);
         blue = int'(b);
         top = red;
         bottom = red;
         if (green > top) top = green;
         if (blue > top) top = blue;
         if (green < bottom) bottom = green;
         if (blue < bottom) bottom = blue;
         spread = top - bottom;
         sum = top + bottom;
         hue = 0;
         sat = longint'(0);
         if (spread != 0) begin
            den = (sum <= 255) ? sum : 510 - sum;
            sat = (longint'(spread) * longint'(SAT_FULL_SCALE)) / longint'(den);
            if (sat > longint'(SAT_FULL_SCALE - 1)) sat = longint'(SAT_FULL_SCALE - 1);
            // red wins ties, then green
            if (top == red) begin
               if (green >= blue)
                  numer = HUE_UNITS_PER_SECTOR * (green - blue);
               else
                  numer = HUE_UNITS_FULL * spread - HUE_UNITS_PER_SECTOR * (blue - green);
            end else if (top == green) begin
               numer = 2 * HUE_UNITS_PER_SECTOR * spread + HUE_UNITS_PER_SECTOR * (blue - red);
            end else begin
               numer = 4 * HUE_UNITS_PER_SECTOR * spread + HUE_UNITS_PER_SECTOR * (red - green);
            end
            hue = numer / spread;
            if (hue >= HUE_UNITS_FULL) hue = HUE_UNITS_FULL - 1;
         end
         res.hue = r2h_pkg::HUE_W'(hue);
         res.saturation = r2h_pkg::SAT_W'(sat);
         res.lightness_sum = r2h_pkg::SUM_W'(sum);
         return res;
      endfunction

      function void note_pixel(logic [r2h_pkg::CHAN_W-1:0] r,
                               logic [r2h_pkg::CHAN_W-1:0] g,
                               logic [r2h_pkg::CHAN_W-1:0] b);
         awaited.push_back(convert_pixel(r, g, b));
      endfunction

      function void check_result(logic [r2h_pkg::HUE_W-1:0] hue,
                                 logic [r2h_pkg::SAT_W-1:0] sat,
                                 logic [r2h_pkg::SUM_W-1:0] sum);
         hsl_result_type want;
         if (awaited.size() == 0) begin
            $error("response with no pixel outstanding: hue %0d sat %0d sum %0d",
                   hue, sat, sum);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (hue !== want.hue) begin
            $error("hue: expected %0d, actual %0d", want.hue, hue);
            failures++;
         end
         if (sat !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation, sat);
            failures++;
         end
         if (sum !== want.lightness_sum) begin
            $error("lightness_sum: expected %0d, actual %0d", want.lightness_sum, sum);
            failures++;
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block under test
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [r2h_pkg::CHAN_W-1:0] req_red = '0;
   logic [r2h_pkg::CHAN_W-1:0] req_green = '0;
   logic [r2h_pkg::CHAN_W-1:0] req_blue = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [r2h_pkg::HUE_W-1:0] rsp_hue;
   logic [r2h_pkg::SAT_W-1:0] rsp_saturation;
   logic [r2h_pkg::SUM_W-1:0] rsp_lightness_sum;

   pixel_scoreboard sb;
   int unsigned pixels_in = 0;
   int unsigned quiet_cycles = 0;

   rgb_to_hsl_pixel_converter_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hue           (rsp_hue),
      .rsp_saturation    (rsp_saturation),
      .rsp_lightness_sum (rsp_lightness_sum)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // monitors: both channels sampled at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_pixel(req_red, req_green, req_blue);
         pixels_in++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_hue, rsp_saturation, rsp_lightness_sum);
   end

   // watchdog: a run with no handshake on either channel for too long is hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender tasks: payload changes at the falling edge, request held to accept
   // ------------------------------------------------------------------------
   task automatic send_pixel(input logic [r2h_pkg::CHAN_W-1:0] r,
                             input logic [r2h_pkg::CHAN_W-1:0] g,
                             input logic [r2h_pkg::CHAN_W-1:0] b);
      @(negedge clock);
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // sender goes quiet until every predicted response has come back
   task automatic drain_block();
      sender_gap(1);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [r2h_pkg::CHAN_W-1:0] corner_channel();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd127;
         3: return 8'd128;
         4: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // receiver: stalls on modes of its own, with one long hold-off that backs
   // the pipeline up into the request side
   // ------------------------------------------------------------------------
   initial begin
      int mode;
      int span;
      int phase;
      bit backed_up;
      phase = 0;
      backed_up = 0;
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(32, 200);
         repeat (span) begin
            @(negedge clock);
            if (!backed_up && pixels_in >= BACKUP_AT) begin
               backed_up = 1;
               rsp_ready <= 1'b0;
               repeat (BACKUP_CYCLES) @(negedge clock);
            end
            phase++;
            case (mode)
               0: rsp_ready <= 1'b1;                          // no stalls at all
               1: rsp_ready <= 1'($urandom_range(0, 1));     // coin toss
               2: rsp_ready <= ($urandom_range(0, 3) == 0);  // mostly stalled
               default: rsp_ready <= (phase % 5) != 4;       // regular beat
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      int burst_left;
      int kind;
      logic [r2h_pkg::CHAN_W-1:0] v;
      logic [r2h_pkg::CHAN_W-1:0] w;
      logic [r2h_pkg::CHAN_W-1:0] r;
      logic [r2h_pkg::CHAN_W-1:0] g;
      logic [r2h_pkg::CHAN_W-1:0] b;

      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners
      send_pixel(8'd0, 8'd0, 8'd0);          // black
      send_pixel(8'd255, 8'd255, 8'd255);    // white
      send_pixel(8'd128, 8'd128, 8'd128);    // mid grey
      send_pixel(8'd255, 8'd0, 8'd0);        // pure red
      send_pixel(8'd0, 8'd255, 8'd0);        // pure green
      send_pixel(8'd0, 8'd0, 8'd255);        // pure blue
      send_pixel(8'd255, 8'd255, 8'd0);      // red and green tie
      send_pixel(8'd0, 8'd255, 8'd255);      // green and blue tie
      send_pixel(8'd255, 8'd0, 8'd255);      // red and blue tie
      send_pixel(8'd255, 8'd0, 8'd1);        // red top, hue wraps just below 360
      send_pixel(8'd255, 8'd1, 8'd0);        // red top, hue just above 0
      send_pixel(8'd1, 8'd0, 8'd0);          // full saturation, tiny sum
      send_pixel(8'd255, 8'd254, 8'd254);    // full saturation, sum near top
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd127, 8'd127);    // sum exactly half scale
      send_pixel(8'd128, 8'd128, 8'd127);
      send_pixel(8'd129, 8'd127, 8'd127);    // sum just over half scale
      send_pixel(8'd200, 8'd100, 8'd50);
      send_pixel(8'd10, 8'd200, 8'd30);
      send_pixel(8'd40, 8'd60, 8'd250);
      send_pixel(8'd0, 8'd255, 8'd254);      // green top, blue close behind
      send_pixel(8'd254, 8'd0, 8'd255);      // blue top, red close behind

      burst_left = 0;
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i == PAUSE_AT) drain_block();

         // keep offering without gaps around the long response hold-off
         if (burst_left == 0) begin
            if (!(i >= BACKUP_AT - 40 && i < BACKUP_AT + 300))
               sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            burst_left = $urandom_range(1, 48);
         end

         kind = $urandom_range(0, 99);
         v = r2h_pkg::CHAN_W'($urandom_range(0, 255));
         w = r2h_pkg::CHAN_W'($urandom_range(0, 255));
         if (kind < 55) begin
            r = r2h_pkg::CHAN_W'($urandom_range(0, 255));
            g = r2h_pkg::CHAN_W'($urandom_range(0, 255));
            b = r2h_pkg::CHAN_W'($urandom_range(0, 255));
         end else if (kind < 67) begin
            // grey
            r = v;
            g = v;
            b = v;
         end else if (kind < 82) begin
            // two channels equal, the odd one out placed at random
            case ($urandom_range(0, 2))
               0: begin r = w; g = v; b = v; end
               1: begin r = v; g = w; b = v; end
               default: begin r = v; g = v; b = w; end
            endcase
         end else if (kind < 92) begin
            r = corner_channel();
            g = corner_channel();
            b = corner_channel();
         end else begin
            // nearly grey: channels differ in the lowest bit only
            r = v ^ r2h_pkg::CHAN_W'($urandom_range(0, 1));
            g = v ^ r2h_pkg::CHAN_W'($urandom_range(0, 1));
            b = v ^ r2h_pkg::CHAN_W'($urandom_range(0, 1));
         end
         send_pixel(r, g, b);
         burst_left--;
      end

      drain_block();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== rgb_to_hsl_pixel_converter_unit.f =====
+incdir+rtl/core
rtl/core/r2h_pkg.sv
rtl/core/r2h_divider.sv
rtl/core/rgb_to_hsl_pixel_converter_unit.sv
bench/tb.sv
